@@ rtl/hilbert_golden_ratio_dither_top_assert.svh @@
// assertion macros for the dither top level
`ifndef HILBERT_GOLDEN_RATIO_DITHER_TOP_ASSERT_SVH
`define HILBERT_GOLDEN_RATIO_DITHER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define HGRD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hgrd assertion failed");

// next-cycle implication, checked outside reset
`define HGRD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hgrd assertion failed");

`endif

@@ rtl/hgrd_pkg.sv @@
package hgrd_pkg;

  localparam int LEVEL_BITS = 15;
  localparam int COORD_W    = 15;
  localparam int LVL_W      = 4;
  localparam int IDX_W      = 2 * LEVEL_BITS;
  localparam int MOD_BITS   = 17;
  localparam int CFG_W      = 4;
  localparam int DITHER_W   = 8;
  localparam int FRAC_W     = 32;

  localparam logic [FRAC_W-1:0]  PHI_Q32   = 32'h9E3779B9;
  localparam logic [FRAC_W-1:0]  HALF_Q32  = 32'h80000000;
  localparam logic [CFG_W-1:0]   GRID_RST  = 4'd8;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [IDX_W-1:0]   idx;
  } cell_t;

  typedef struct packed {
    logic en;
    logic prod_valid;
    logic skid_valid;
  } mix_stat_t;

endpackage

@@ rtl/hgrd_in_if.sv @@
interface hgrd_in_if;
  logic                         valid;
  logic                         ready;
  logic [hgrd_pkg::COORD_W-1:0] pos_x;
  logic [hgrd_pkg::COORD_W-1:0] pos_y;

  modport source (output valid, output pos_x, output pos_y, input ready);
  modport sink (input valid, input pos_x, input pos_y, output ready);
endinterface

@@ rtl/hgrd_out_if.sv @@
interface hgrd_out_if;
  logic                          valid;
  logic                          ready;
  logic [hgrd_pkg::DITHER_W-1:0] dither_value;
  logic [hgrd_pkg::IDX_W-1:0]    curve_index;

  modport source (output valid, output dither_value, output curve_index, input ready);
  modport sink (input valid, input dither_value, input curve_index, output ready);
endinterface

@@ rtl/hgrd_cell.sv @@
module hgrd_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic [hgrd_pkg::LVL_W-1:0]   lvl,
  input  logic [hgrd_pkg::COORD_W-1:0] wmax,
  input  logic                         valid_in,
  input  hgrd_pkg::cell_t              data_in,
  output logic                         valid_out,
  output hgrd_pkg::cell_t              data_out
);

  logic                         rx;
  logic                         ry;
  logic [1:0]                   quad;
  logic [hgrd_pkg::COORD_W-1:0] xr;
  logic [hgrd_pkg::COORD_W-1:0] yr;
  hgrd_pkg::cell_t              data_next;

  always_comb begin
    rx   = data_in.x[lvl];
    ry   = data_in.y[lvl];
    quad = {rx, rx ^ ry};
    xr   = rx ? (wmax - data_in.x) : data_in.x;
    yr   = rx ? (wmax - data_in.y) : data_in.y;
    data_next.idx = data_in.idx |
                    (hgrd_pkg::IDX_W'(quad) << {lvl, 1'b0});
    if (!ry) begin
      // reflect on the right half, then swap
      data_next.x = yr;
      data_next.y = xr;
    end else begin
      data_next.x = data_in.x;
      data_next.y = data_in.y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_out <= data_next;
    end
  end

endmodule

@@ rtl/hgrd_mix.sv @@
module hgrd_mix (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 valid_in,
  input  hgrd_pkg::cell_t      data_in,
  output hgrd_pkg::mix_stat_t  stat,
  hgrd_out_if.source           dout
);

  logic                          prod_valid;
  logic [hgrd_pkg::DITHER_W-1:0] prod_dither;
  logic [hgrd_pkg::IDX_W-1:0]    prod_idx;
  logic                          skid_valid;
  logic [hgrd_pkg::DITHER_W-1:0] skid_dither;
  logic [hgrd_pkg::IDX_W-1:0]    skid_idx;
  logic                          en;
  logic [hgrd_pkg::FRAC_W-1:0]   frac_next;

  assign en = !skid_valid;

  // c = half + phi * (index mod 2^MOD_BITS), wrapped to 32 bits
  assign frac_next = hgrd_pkg::HALF_Q32 +
                     hgrd_pkg::PHI_Q32 *
                     hgrd_pkg::FRAC_W'(data_in.idx[hgrd_pkg::MOD_BITS-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (en) begin
      prod_valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_dither <= frac_next[hgrd_pkg::FRAC_W-1 -: hgrd_pkg::DITHER_W];
      prod_idx    <= data_in.idx;
    end
  end

  // skid catches the word in the product stage when the sink stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (dout.ready) begin
        skid_valid <= 1'b0;
      end
    end else if (prod_valid && !dout.ready) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_valid) begin
      skid_dither <= prod_dither;
      skid_idx    <= prod_idx;
    end
  end

  assign dout.valid        = skid_valid || prod_valid;
  assign dout.dither_value = skid_valid ? skid_dither : prod_dither;
  assign dout.curve_index  = skid_valid ? skid_idx : prod_idx;

  assign stat.en         = en;
  assign stat.prod_valid = prod_valid;
  assign stat.skid_valid = skid_valid;

endmodule

@@ rtl/hilbert_golden_ratio_dither_top.sv @@
// throughput: one word per cycle while the output sink does not stall, set by a 15-cell chain (one cell per curve
//   level) followed by one multiply stage and an output skid register
// reset: rst synchronous, active high; clears all valid bits and loads the
//   grid log2 register with 8
module hilbert_golden_ratio_dither_top (
  input  logic                       clk,
  input  logic                       rst,
  hgrd_in_if.sink                    coord,
  hgrd_out_if.source                 dither,
  input  logic                       cfg_we,
  input  logic [hgrd_pkg::CFG_W-1:0] cfg_data
);

  localparam int N = hgrd_pkg::LEVEL_BITS;

  logic [hgrd_pkg::COORD_W-1:0] wmax;
  logic [hgrd_pkg::COORD_W:0]   wfull;
  logic [hgrd_pkg::CFG_W-1:0]   grid_log2;
  logic                         chain_valid [0:N];
  hgrd_pkg::cell_t              chain_data  [0:N];
  hgrd_pkg::mix_stat_t          stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_log2 <= hgrd_pkg::GRID_RST;
    end else if (cfg_we) begin
      grid_log2 <= cfg_data;
    end
  end

  // reflection point w - 1, only the coordinate bits matter
  assign wfull = ({{hgrd_pkg::COORD_W{1'b0}}, 1'b1} << grid_log2) -
                 {{hgrd_pkg::COORD_W{1'b0}}, 1'b1};
  assign wmax  = wfull[hgrd_pkg::COORD_W-1:0];

  assign coord.ready        = stat.en;
  assign chain_valid[0]     = coord.valid;
  assign chain_data[0].x    = coord.pos_x;
  assign chain_data[0].y    = coord.pos_y;
  assign chain_data[0].idx  = '0;

  // cell k handles the curve level N-1-k, top level first
  for (genvar k = 0; k < N; k++) begin : g_cell
    hgrd_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (stat.en),
      .lvl       (hgrd_pkg::LVL_W'(N - 1 - k)),
      .wmax      (wmax),
      .valid_in  (chain_valid[k]),
      .data_in   (chain_data[k]),
      .valid_out (chain_valid[k+1]),
      .data_out  (chain_data[k+1])
    );
  end

  hgrd_mix u_mix (
    .clk      (clk),
    .rst      (rst),
    .valid_in (chain_valid[N]),
    .data_in  (chain_data[N]),
    .stat     (stat),
    .dout     (dither)
  );

`include "hilbert_golden_ratio_dither_top_assert.svh"

  `HGRD_ASSERT_NEXT(a_chain_to_mult, stat.en && chain_valid[N], stat.prod_valid)
  `HGRD_ASSERT_NEXT(a_frozen_holds, stat.prod_valid && !stat.en, stat.prod_valid)
  `HGRD_ASSERT_NEXT(a_skid_holds, stat.skid_valid && !dither.ready, stat.skid_valid)
  `HGRD_ASSERT_NOW(a_zero_index, dither.valid && (dither.curve_index == '0), dither.dither_value == 8'h80)

endmodule

@@ tb/sv/hilbert_golden_ratio_dither_top_tb.sv @@
`timescale 1ns / 1ps

module hilbert_golden_ratio_dither_top_tb;
  import hgrd_pkg::*;

  localparam int HALF_PERIOD  = 10;
  localparam int RESET_CYCLES = 8;
  localparam int DRAIN_CYCLES = 24;
  localparam int STALL_LIMIT  = 3000;
  localparam int HOLD_AT_WORD = 200;
  localparam int HOLD_CYCLES  = 80;
  localparam int MAX_REPORTS  = 30;

  typedef struct packed {
    logic [DITHER_W-1:0] dither;
    logic [IDX_W-1:0]    index;
  } dither_word_t;

  class dither_scoreboard;
    dither_word_t     expected_q[$];
    logic [CFG_W-1:0] grid;
    int               errors;
    int               checked;
    int               noted;

    function new();
      grid    = GRID_RST;
      errors  = 0;
      checked = 0;
      noted   = 0;
    endfunction

    // walk the curve from the top level down and form the golden-ratio threshold
    function void note_coord(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py);
      logic [31:0]  cx;
      logic [31:0]  cy;
      logic [31:0]  swap;
      logic [31:0]  reflect;
      logic [31:0]  curve;
      logic [31:0]  mix;
      logic         rx;
      logic         ry;
      dither_word_t want;
      cx      = 32'(px);
      cy      = 32'(py);
      reflect = (32'd1 << grid) - 32'd1;
      curve   = '0;
      for (int lvl = LEVEL_BITS - 1; lvl >= 0; lvl--) begin
        rx = cx[lvl];
        ry = cy[lvl];
        // quadrant term is (3*rx) ^ ry
        curve += {30'd0, rx, rx ^ ry} << (2 * lvl);
        if (!ry) begin
          if (rx) begin
            cx = reflect - cx;
            cy = reflect - cy;
          end
          swap = cx;
          cx   = cy;
          cy   = swap;
        end
      end
      mix         = HALF_Q32 + PHI_Q32 * (curve & ((32'd1 << MOD_BITS) - 32'd1));
      want.dither = mix[FRAC_W-1 -: DITHER_W];
      want.index  = curve[IDX_W-1:0];
      expected_q.push_back(want);
      noted++;
    endfunction

    task report_mismatch(string what, longint unsigned got, longint unsigned want);
      if (errors < MAX_REPORTS)
        $display("[%0t] mismatch %s: got 0x%0h expected 0x%0h", $time, what, got, want);
      errors++;
    endtask

    task check_word(logic [DITHER_W-1:0] dv, logic [IDX_W-1:0] ci);
      dither_word_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("word with no coordinate waiting", ci, 0);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (dv !== want.dither)
        report_mismatch("dither_value", dv, want.dither);
      if (ci !== want.index)
        report_mismatch("curve_index", ci, want.index);
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_data;
  logic             steady;
  int               settings_used;
  int               coords_sent;

  dither_scoreboard scores = new();

  hgrd_in_if  coord_if ();
  hgrd_out_if dither_if ();

  hilbert_golden_ratio_dither_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .coord    (coord_if),
    .dither   (dither_if),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always #(HALF_PERIOD) clk = ~clk;

  task automatic send_coord(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py);
    int gap;
    gap = 0;
    if (!steady && $urandom_range(0, 99) < 10)
      gap = $urandom_range(1, 4);
    if (gap > 0) begin
      coord_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    coord_if.valid <= 1'b1;
    coord_if.pos_x <= px;
    coord_if.pos_y <= py;
    @(posedge clk);
    while (!coord_if.ready) @(posedge clk);
    scores.note_coord(px, py);
    coords_sent++;
  endtask

  task automatic finish_batch();
    coord_if.valid <= 1'b0;
    while (scores.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_grid(logic [CFG_W-1:0] g);
    cfg_we   <= 1'b1;
    cfg_data <= g;
    @(posedge clk);
    cfg_we      <= 1'b0;
    scores.grid  = g;
    settings_used++;
  endtask

  task automatic random_batch(int count);
    logic [31:0] span;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    span = (32'd1 << scores.grid) - 32'd1;
    if (span > 32'h7FFF)
      span = 32'h7FFF;
    repeat (count) begin
      // mostly inside the grid, some anywhere in the field
      if ($urandom_range(0, 99) < 85) begin
        px = COORD_W'($urandom_range(0, span));
        py = COORD_W'($urandom_range(0, span));
      end else begin
        px = COORD_W'($urandom_range(0, 32'h7FFF));
        py = COORD_W'($urandom_range(0, 32'h7FFF));
      end
      send_coord(px, py);
    end
  endtask

  // output side: checks each word, idles at random, one long hold-off
  initial begin : word_sink
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 0;
    dither_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        dither_if.ready <= 1'b0;
      end else begin
        if (dither_if.valid && dither_if.ready)
          scores.check_word(dither_if.dither_value, dither_if.curve_index);
        if (!hold_done && scores.checked == HOLD_AT_WORD) begin
          hold_left = HOLD_CYCLES;
          hold_done = 1;
        end
        if (hold_left > 0) begin
          hold_left--;
          dither_if.ready <= 1'b0;
        end else begin
          dither_if.ready <= steady || ($urandom_range(0, 99) >= 20);
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((coord_if.valid && coord_if.ready) || (dither_if.valid && dither_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    logic [CFG_W-1:0] grid_plan[6];
    int               leftover;
    rst            <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_data       <= '0;
    steady         <= 1'b0;
    coord_if.valid <= 1'b0;
    coord_if.pos_x <= '0;
    coord_if.pos_y <= '0;
    settings_used   = 1;
    coords_sent     = 0;
    grid_plan       = '{4'd1, 4'd5, 4'd8, 4'd12, 4'd3, 4'd15};
    grid_plan[4]    = CFG_W'($urandom_range(1, 14));
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset grid setting: corners, in-grid limits, alternating bits
    send_coord(15'h0000, 15'h0000);
    send_coord(15'h00FF, 15'h00FF);
    send_coord(15'h00FF, 15'h0000);
    send_coord(15'h0000, 15'h00FF);
    send_coord(15'h7FFF, 15'h7FFF);
    send_coord(15'h7FFF, 15'h0000);
    send_coord(15'h0000, 15'h7FFF);
    send_coord(15'h5555, 15'h2AAA);
    send_coord(15'h2AAA, 15'h5555);
    send_coord(15'h0080, 15'h0000);
    send_coord(15'h0000, 15'h0080);
    send_coord(15'h0064, 15'h00C8);
    finish_batch();

    // grid log zero: reflection point collapses to zero
    write_grid(4'd0);
    send_coord(15'h0000, 15'h0000);
    send_coord(15'h0001, 15'h0001);
    send_coord(15'h7FFF, 15'h0000);
    send_coord(15'h0000, 15'h7FFF);
    random_batch(50);
    finish_batch();

    // widest grid, no idling on either side
    write_grid(4'd15);
    steady <= 1'b1;
    send_coord(15'h7FFF, 15'h7FFF);
    send_coord(15'h4000, 15'h0000);
    send_coord(15'h0000, 15'h4000);
    random_batch(55);
    finish_batch();
    steady <= 1'b0;

    foreach (grid_plan[i]) begin
      write_grid(grid_plan[i]);
      random_batch(56);
      finish_batch();
    end

    leftover = scores.pending();
    if (leftover != 0)
      scores.report_mismatch("words never produced", leftover, 0);
    $display("run covered %0d coordinate words over %0d grid settings, with a long output hold",
             coords_sent, settings_used);
    $display("words checked %0d, mismatches %0d", scores.checked, scores.errors);
    if (scores.errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
